// ===== hw/rtl/vt100_subset_text_terminal_defines.svh =====
// assertion macros shared by the terminal checker
// no dependencies; each use names its own clock and reset
`ifndef VT100_SUBSET_TEXT_TERMINAL_DEFINES_SVH
`define VT100_SUBSET_TEXT_TERMINAL_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define VTT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define VTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/vtt_pkg.sv =====
// shared types, constants and helper functions of the text terminal
// no dependencies
package vtt_pkg;

  localparam int ARG_BITS   = 16;
  localparam int ARG_WIDE   = ARG_BITS + 4;
  localparam int COORD_BITS = 8;
  localparam int SAT_W      = (ARG_BITS > COORD_BITS) ? ARG_BITS : COORD_BITS;
  localparam int BYTE_W     = 8;
  localparam int REG_W      = 8;
  localparam int CMPW       = ((COORD_BITS > REG_W) ? COORD_BITS : REG_W) + 1;
  localparam int OUT_W      = 8;
  localparam int CMD_W      = 3;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int MAX_CMDS   = 4;
  localparam int SLOT_W     = 2;
  localparam int QDEPTH     = 2;  // power of two
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = QPTR_W + 1;

  localparam logic [ARG_BITS-1:0]   ARG_MAX   = {ARG_BITS{1'b1}};
  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

  localparam logic [REG_W-1:0] COLUMNS_RST = REG_W'(125);
  localparam logic [REG_W-1:0] ROWS_RST    = REG_W'(75);

  // register indexes on the config port
  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_COLUMNS = 1'b0;
  localparam reg_idx_t REG_ROWS    = 1'b1;

  // stream characters
  localparam logic [BYTE_W-1:0] CH_ESC  = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_LBR  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_H    = 8'h48;
  localparam logic [BYTE_W-1:0] CH_J    = 8'h4A;
  localparam logic [BYTE_W-1:0] CH_X    = 8'h58;
  localparam logic [BYTE_W-1:0] CH_NL   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BS   = 8'h08;
  localparam logic [BYTE_W-1:0] CH_D0   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_D9   = 8'h39;
  localparam logic [ARG_BITS-1:0] ARG_TWO = ARG_BITS'(2);

  typedef logic [CMD_W-1:0] cmd_code_t;
  localparam cmd_code_t CMD_GLYPH  = 3'd0;
  localparam cmd_code_t CMD_BACK   = 3'd1;
  localparam cmd_code_t CMD_CURSOR = 3'd2;
  localparam cmd_code_t CMD_SCROLL = 3'd3;
  localparam cmd_code_t CMD_CLRROW = 3'd4;
  localparam cmd_code_t CMD_CLRSCR = 3'd5;

  typedef struct packed {
    cmd_code_t               command;
    logic [COORD_BITS-1:0]   col;
    logic [COORD_BITS-1:0]   row;
    logic [BYTE_W-1:0]       glyph;
  } cmd_t;

  // all drawing commands caused by one byte, slot 0 first
  typedef struct packed {
    logic [SLOT_W-1:0]       last_slot;
    cmd_t [MAX_CMDS-1:0]     cmds;
  } plan_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic cmd_t mk_cmd(input cmd_code_t code,
                                  input logic [COORD_BITS-1:0] col,
                                  input logic [COORD_BITS-1:0] row,
                                  input logic [BYTE_W-1:0] glyph);
    cmd_t c;
    c.command = code;
    c.col     = col;
    c.row     = row;
    c.glyph   = glyph;
    return c;
  endfunction

  function automatic logic [COORD_BITS-1:0] row_inc(input logic [COORD_BITS-1:0] r);
    return (r == COORD_MAX) ? r : r + COORD_BITS'(1);
  endfunction

  // a*10 + d, saturating
  function automatic logic [ARG_BITS-1:0] arg_step(input logic [ARG_BITS-1:0] a,
                                                   input logic [3:0] d);
    logic [ARG_WIDE-1:0] v;
    v = (ARG_WIDE'(a) << 3) + (ARG_WIDE'(a) << 1) + ARG_WIDE'(d);
    return (v > ARG_WIDE'(ARG_MAX)) ? ARG_MAX : v[ARG_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] coord_sat(input logic [ARG_BITS-1:0] a);
    return (SAT_W'(a) > SAT_W'(COORD_MAX)) ? COORD_MAX : COORD_BITS'(a);
  endfunction

endpackage

// ===== hw/rtl/vtt_front.sv =====
// front end: escape parser and cursor tracking, builds at most one command plan per byte
// depends on vtt_pkg
module vtt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [vtt_pkg::BYTE_W-1:0]    byte_req,
  input  logic [vtt_pkg::REG_W-1:0]     columns,
  input  logic [vtt_pkg::REG_W-1:0]     rows,
  output logic                          push,
  output vtt_pkg::plan_t                plan
);

  typedef enum logic [1:0] {PH_TEXT, PH_ESC, PH_ARG1, PH_ARG2} phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [vtt_pkg::ARG_BITS-1:0]    arg_one_r, arg_one_nxt, arg_two_r, arg_two_nxt;
  logic [vtt_pkg::COORD_BITS-1:0]  cur_col_r, cur_col_nxt, cur_row_r, cur_row_nxt;
  logic [vtt_pkg::COORD_BITS-1:0]  shown_col_r, shown_col_nxt, shown_row_r, shown_row_nxt;
  logic                            raw_r, raw_nxt;

  // glyph placement
  logic                            gl_scroll, gl_wrap;
  logic [vtt_pkg::COORD_BITS-1:0]  gl_up, gl_col, gl_row, gl_ncol, gl_nrow, bs_col;
  logic [vtt_pkg::CMPW-1:0]        gl_col1, gl_limit;

  // printing a byte
  vtt_pkg::plan_t                  pr_plan, fin_plan;
  logic [vtt_pkg::COORD_BITS-1:0]  pr_col, pr_row;
  logic                            pr_show;
  logic                            digit, push_c;

  assign digit = (byte_req >= vtt_pkg::CH_D0) && (byte_req <= vtt_pkg::CH_D9);

  assign gl_scroll = vtt_pkg::CMPW'(cur_row_r) >= vtt_pkg::CMPW'(rows);
  assign gl_up     = (cur_row_r == '0) ? '0 : cur_row_r - vtt_pkg::COORD_BITS'(1);
  assign gl_col    = gl_scroll ? '0 : cur_col_r;
  assign gl_row    = gl_scroll ? gl_up : cur_row_r;
  assign gl_col1   = vtt_pkg::CMPW'(gl_col) + vtt_pkg::CMPW'(1);
  assign gl_limit  = (columns == '0) ? '0 : vtt_pkg::CMPW'(columns) - vtt_pkg::CMPW'(1);
  assign gl_wrap   = gl_col1 >= gl_limit;
  assign gl_ncol   = gl_wrap ? '0 : gl_col1[vtt_pkg::COORD_BITS-1:0];
  assign gl_nrow   = gl_wrap ? vtt_pkg::row_inc(gl_row) : gl_row;
  assign bs_col    = (cur_col_r == '0) ? '0 : cur_col_r - vtt_pkg::COORD_BITS'(1);

  always_comb begin
    pr_plan = '0;
    pr_col  = cur_col_r;
    pr_row  = cur_row_r;
    pr_show = 1'b0;
    if (raw_r) begin
      pr_plan.cmds[0] = vtt_pkg::mk_cmd(vtt_pkg::CMD_GLYPH, cur_col_r, cur_row_r, byte_req);
      pr_plan.cmds[1] = vtt_pkg::mk_cmd(vtt_pkg::CMD_BACK, shown_col_r, shown_row_r, '0);
      pr_plan.last_slot = vtt_pkg::SLOT_W'(1);
    end else if (byte_req == vtt_pkg::CH_BS) begin
      pr_plan.cmds[0] = vtt_pkg::mk_cmd(vtt_pkg::CMD_BACK, cur_col_r, cur_row_r, '0);
      pr_plan.cmds[1] = vtt_pkg::mk_cmd(vtt_pkg::CMD_BACK, bs_col, cur_row_r, '0);
      pr_plan.cmds[2] = vtt_pkg::mk_cmd(vtt_pkg::CMD_CURSOR, bs_col, cur_row_r, '0);
      pr_plan.last_slot = vtt_pkg::SLOT_W'(2);
      pr_col  = bs_col;
      pr_show = 1'b1;
    end else if (byte_req == vtt_pkg::CH_NL) begin
      pr_col  = '0;
      pr_row  = vtt_pkg::row_inc(cur_row_r);
      pr_plan.cmds[0] = vtt_pkg::mk_cmd(vtt_pkg::CMD_BACK, shown_col_r, shown_row_r, '0);
      pr_plan.cmds[1] = vtt_pkg::mk_cmd(vtt_pkg::CMD_CURSOR, '0, pr_row, '0);
      pr_plan.last_slot = vtt_pkg::SLOT_W'(1);
      pr_show = 1'b1;
    end else begin
      pr_col  = gl_ncol;
      pr_row  = gl_nrow;
      pr_show = 1'b1;
      if (gl_scroll) begin
        pr_plan.cmds[0] = vtt_pkg::mk_cmd(vtt_pkg::CMD_SCROLL, '0, '0, '0);
        pr_plan.cmds[1] = vtt_pkg::mk_cmd(vtt_pkg::CMD_CLRROW, '0, gl_up, '0);
        pr_plan.cmds[2] = vtt_pkg::mk_cmd(vtt_pkg::CMD_GLYPH, gl_col, gl_row, byte_req);
        pr_plan.cmds[3] = vtt_pkg::mk_cmd(vtt_pkg::CMD_CURSOR, gl_ncol, gl_nrow, '0);
        pr_plan.last_slot = vtt_pkg::SLOT_W'(3);
      end else begin
        pr_plan.cmds[0] = vtt_pkg::mk_cmd(vtt_pkg::CMD_GLYPH, gl_col, gl_row, byte_req);
        pr_plan.cmds[1] = vtt_pkg::mk_cmd(vtt_pkg::CMD_CURSOR, gl_ncol, gl_nrow, '0);
        pr_plan.last_slot = vtt_pkg::SLOT_W'(1);
      end
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    arg_one_nxt   = arg_one_r;
    arg_two_nxt   = arg_two_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    shown_col_nxt = shown_col_r;
    shown_row_nxt = shown_row_r;
    raw_nxt       = raw_r;
    fin_plan      = '0;
    push_c        = 1'b0;
    if (accept) begin
      unique case (phase_r) inside
        PH_ESC: begin
          if (byte_req == vtt_pkg::CH_LBR) begin
            phase_nxt = PH_ARG1;
          end else begin
            phase_nxt   = PH_TEXT;
            arg_one_nxt = '0;
            arg_two_nxt = '0;
          end
        end
        PH_ARG1, PH_ARG2: begin
          if (digit) begin
            if (phase_r == PH_ARG1) begin
              arg_one_nxt = vtt_pkg::arg_step(arg_one_r, byte_req[3:0]);
            end else begin
              arg_two_nxt = vtt_pkg::arg_step(arg_two_r, byte_req[3:0]);
            end
          end else if (byte_req == vtt_pkg::CH_SEMI) begin
            phase_nxt = PH_ARG2;
          end else begin
            phase_nxt   = PH_TEXT;
            arg_one_nxt = '0;
            arg_two_nxt = '0;
            if (byte_req == vtt_pkg::CH_H) begin
              cur_col_nxt = vtt_pkg::coord_sat(arg_one_r);
              cur_row_nxt = vtt_pkg::coord_sat(arg_two_r);
              fin_plan.cmds[0] = vtt_pkg::mk_cmd(vtt_pkg::CMD_BACK, shown_col_r,
                                                 shown_row_r, '0);
              push_c = 1'b1;
            end else if (byte_req == vtt_pkg::CH_J && phase_r == PH_ARG1 &&
                         arg_one_r == vtt_pkg::ARG_TWO) begin
              fin_plan.cmds[0] = vtt_pkg::mk_cmd(vtt_pkg::CMD_CLRSCR, '0, '0, '0);
              push_c = 1'b1;
            end else if (byte_req == vtt_pkg::CH_X) begin
              raw_nxt = 1'b1;
            end else if (byte_req == vtt_pkg::CH_ESC) begin
              phase_nxt = PH_ESC;
            end else begin
              cur_col_nxt = pr_col;
              cur_row_nxt = pr_row;
              if (pr_show) begin
                shown_col_nxt = pr_col;
                shown_row_nxt = pr_row;
              end
              fin_plan = pr_plan;
              push_c   = 1'b1;
            end
          end
        end
        default: begin
          if (byte_req == vtt_pkg::CH_ESC) begin
            phase_nxt = PH_ESC;
          end else begin
            cur_col_nxt = pr_col;
            cur_row_nxt = pr_row;
            if (pr_show) begin
              shown_col_nxt = pr_col;
              shown_row_nxt = pr_row;
            end
            fin_plan = pr_plan;
            push_c   = 1'b1;
          end
        end
      endcase
    end
  end

  assign push = push_c;
  assign plan = fin_plan;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TEXT;
      arg_one_r   <= '0;
      arg_two_r   <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      shown_col_r <= '0;
      shown_row_r <= '0;
      raw_r       <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      arg_one_r   <= arg_one_nxt;
      arg_two_r   <= arg_two_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      shown_col_r <= shown_col_nxt;
      shown_row_r <= shown_row_nxt;
      raw_r       <= raw_nxt;
    end
  end

endmodule

// ===== hw/rtl/vtt_queue.sv =====
// short plan queue between the parser front end and the command sequencer
// depends on vtt_pkg
module vtt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  vtt_pkg::plan_t    push_plan,
  input  logic              pop,
  output vtt_pkg::plan_t    head,
  output vtt_pkg::q_stat_t  stat
);

  vtt_pkg::plan_t               slots_r [vtt_pkg::QDEPTH];
  logic [vtt_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [vtt_pkg::QCNT_W-1:0]   count_r;

  assign head       = slots_r[rd_ptr_r];
  assign stat.full  = count_r == vtt_pkg::QCNT_W'(vtt_pkg::QDEPTH);
  assign stat.empty = count_r == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_plan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + vtt_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + vtt_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + vtt_pkg::QCNT_W'(1);
        2'b01:   count_r <= count_r - vtt_pkg::QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/vtt_back.sv =====
// back end: walks the head plan one command per beat into the output register
// depends on vtt_pkg
module vtt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  vtt_pkg::plan_t    head,
  input  vtt_pkg::q_stat_t  stat,
  input  logic              out_stall,
  output logic              pop,
  output logic              out_valid,
  output vtt_pkg::cmd_t     out_cmd,
  output logic              out_last
);

  logic [vtt_pkg::SLOT_W-1:0] slot_r;
  logic                       valid_r, last_r, load, is_last;
  vtt_pkg::cmd_t              cmd_r;

  assign load    = !stat.empty && (!valid_r || !out_stall);
  assign is_last = slot_r == head.last_slot;
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      slot_r  <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      slot_r  <= is_last ? '0 : slot_r + vtt_pkg::SLOT_W'(1);
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r  <= head.cmds[slot_r];
      last_r <= is_last;
    end
  end

  assign out_valid = valid_r;
  assign out_cmd   = cmd_r;
  assign out_last  = last_r;

endmodule

// ===== hw/rtl/vt100_subset_text_terminal.sv =====
// top level of the character-cell text terminal: config registers, parser front end,
// plan queue and command sequencer; depends on vtt_pkg, vtt_front, vtt_queue, vtt_back
//
// usage
//   input channel: one stream byte per beat on in_byte_req, taken at an edge with
//   in_valid high and in_stall low. each byte yields zero to four drawing beats on
//   the output channel (glyph, background cell, cursor cell, scroll, clear row,
//   clear screen); out_last marks the final beat of a byte
//   path: the first beat of a byte reaches the output through the plan queue, then
//   the output register; further beats follow one per cycle while out_stall is low
//   throughput: the sequencer sends one beat per cycle while out_stall is low; a byte
//   causes at most four beats (scroll); the parser takes a byte every cycle while
//   the two-plan queue has room
//   bytes that draw nothing (escape bytes, arguments) never enter the queue
//   in_stall is high only when the plan queue is full
//   when out_stall is high the output register holds its beat and the queue
//   fills; the parser keeps taking bytes until the queue is full
//   reset (synchronous, active low): parser idle, cursor and shown cursor at
//   cell 0,0, cooked mode, columns 125, rows 75, queue and output empty
//   config: APB-style writes; columns at byte address 0, rows at 4; change
//   them only while the block is idle
module vt100_subset_text_terminal (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte stream
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [vtt_pkg::BYTE_W-1:0]    in_byte_req,
  // drawing commands
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vtt_pkg::CMD_W-1:0]     out_command,
  output logic [vtt_pkg::OUT_W-1:0]     out_col,
  output logic [vtt_pkg::OUT_W-1:0]     out_row,
  output logic [vtt_pkg::BYTE_W-1:0]    out_glyph,
  output logic                          out_last,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vtt_pkg::CFG_AW-1:0]    paddr,
  input  logic [vtt_pkg::CFG_DW-1:0]    pwdata,
  output logic [vtt_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  logic [vtt_pkg::REG_W-1:0] columns_r, rows_r;
  vtt_pkg::reg_idx_t         reg_idx;
  logic                      cfg_wr;

  vtt_pkg::plan_t            plan, head;
  vtt_pkg::q_stat_t          q_stat;
  vtt_pkg::cmd_t             cmd;
  logic                      accept, push, pop;

  // register port: always ready, index from the word address
  assign pready  = 1'b1;
  assign reg_idx = paddr[vtt_pkg::CFG_AW-1];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= vtt_pkg::COLUMNS_RST;
      rows_r    <= vtt_pkg::ROWS_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        vtt_pkg::REG_COLUMNS: columns_r <= pwdata[vtt_pkg::REG_W-1:0];
        vtt_pkg::REG_ROWS:    rows_r    <= pwdata[vtt_pkg::REG_W-1:0];
        default:              columns_r <= columns_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      vtt_pkg::REG_COLUMNS: prdata = vtt_pkg::CFG_DW'(columns_r);
      vtt_pkg::REG_ROWS:    prdata = vtt_pkg::CFG_DW'(rows_r);
      default:              prdata = '0;
    endcase
  end

  // byte taken whenever the queue can hold its plan
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  vtt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .byte_req (in_byte_req),
    .columns  (columns_r),
    .rows     (rows_r),
    .push     (push),
    .plan     (plan)
  );

  vtt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_plan (plan),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  vtt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (q_stat),
    .out_stall (out_stall),
    .pop       (pop),
    .out_valid (out_valid),
    .out_cmd   (cmd),
    .out_last  (out_last)
  );

  // cell coordinates widened or cut to the port width
  assign out_command = cmd.command;
  assign out_col     = vtt_pkg::OUT_W'(cmd.col);
  assign out_row     = vtt_pkg::OUT_W'(cmd.row);
  assign out_glyph   = cmd.glyph;

endmodule

// ===== hw/rtl/vtt_checker.sv =====
// port-level checks of the text terminal, bound to the top level
// depends on vtt_pkg and vt100_subset_text_terminal_defines.svh
`include "vt100_subset_text_terminal_defines.svh"

module vtt_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_stall,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [vtt_pkg::CMD_W-1:0]     out_command,
  input  logic [vtt_pkg::OUT_W-1:0]     out_col,
  input  logic [vtt_pkg::OUT_W-1:0]     out_row,
  input  logic [vtt_pkg::BYTE_W-1:0]    out_glyph,
  input  logic                          out_last
);

  // a stalled beat holds
  `VTT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_command) && $stable(out_col) && $stable(out_row) && $stable(out_glyph) && $stable(out_last), "stalled output beat changed")

  // a scroll is always followed at once by the row clear of the same byte
  `VTT_ASSERT_NEXT(a_scroll_clr, clk, rst_n, out_valid && !out_stall && out_command == vtt_pkg::CMD_SCROLL && !out_last, out_valid && out_command == vtt_pkg::CMD_CLRROW, "scroll not followed by row clear")

  // only glyph beats carry a character
  `VTT_ASSERT_SAME(a_glyph_zero, clk, rst_n, out_valid && out_command != vtt_pkg::CMD_GLYPH, out_glyph == '0, "glyph set on a non-glyph command")

  // reset leaves both channels empty and ready
  `VTT_ASSERT_SAME(a_reset_idle, clk, rst_n, $past(!rst_n), !out_valid && !in_stall, "channels busy right after reset")

endmodule

bind vt100_subset_text_terminal vtt_checker u_vtt_checker (.*);
